// ===== rtl/vna_pkg.sv =====
// shared constants and types for the vertex normal accumulator
// no dependencies; imported by vna_unit_vec, the top level and the testbench
package vna_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int POS_W        = 32;
    localparam int SUM_WIDTH    = 24;
    localparam int VEC_W        = 48;
    localparam int NRM_W        = 16;

    typedef enum logic [1:0] {
        OP_STORE = 2'd0,
        OP_FACE  = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [NRM_W-1:0] nrm_t;

endpackage

// ===== rtl/vna_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/vna_unit_vec.sv =====
// iterative unit-vector unit: scale, sum of squares, bit-serial square root,
// restoring division per component; depends on vna_pkg
module vna_unit_vec
    import vna_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  vec_t vin_x,
    input  vec_t vin_y,
    input  vec_t vin_z,
    output logic done,
    output nrm_t q_x,
    output nrm_t q_y,
    output nrm_t q_z
);

    localparam int SQ_W  = 63;
    localparam int NR_W  = 31;
    localparam int DIV_W = 46;
    localparam int QB    = 15;

    typedef enum logic [2:0] {
        U_IDLE, U_NORM, U_SQ, U_SQRT, U_DIVLD, U_DIV
    } ustate_t;

    ustate_t           state_reg;
    logic [VEC_W-1:0]  m_reg [3];
    logic              neg_reg [3];
    logic [SQ_W-1:0]   ss_reg;
    logic [SQ_W-1:0]   x_reg;
    logic [SQ_W-1:0]   r_reg;
    logic [SQ_W-1:0]   bit_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [QB-1:0]     quo_reg;
    logic [3:0]        sh_reg;
    logic [1:0]        idx_reg;
    nrm_t              q_reg [3];
    logic              done_reg;

    logic [VEC_W-1:0]  mag_in [3];
    logic [VEC_W-1:0]  or_m;
    logic [29:0]       m_lo;
    logic [59:0]       sq;
    logic [SQ_W-1:0]   sq_sum;
    logic [SQ_W-1:0]   rb;
    logic [NR_W-1:0]   nrm;
    logic [DIV_W-1:0]  den;
    logic              ge;
    logic [QB-1:0]     quo_next;
    nrm_t              q_signed;

    // magnitudes of the incoming vector
    always_comb
    begin
        mag_in[0] = vin_x[VEC_W-1] ? VEC_W'(-vin_x) : VEC_W'(vin_x);
        mag_in[1] = vin_y[VEC_W-1] ? VEC_W'(-vin_y) : VEC_W'(vin_y);
        mag_in[2] = vin_z[VEC_W-1] ? VEC_W'(-vin_z) : VEC_W'(vin_z);
    end

    // datapath for the scaling, squaring, root and division steps
    always_comb
    begin
        or_m     = m_reg[0] | m_reg[1] | m_reg[2];
        m_lo     = m_reg[idx_reg][29:0];
        sq       = m_lo * m_lo;
        sq_sum   = ss_reg + SQ_W'(sq);
        rb       = r_reg + bit_reg;
        nrm      = r_reg[NR_W-1:0];
        den      = DIV_W'({15'd0, nrm} << sh_reg);
        ge       = (rem_reg >= den);
        quo_next = quo_reg | (ge ? QB'(QB'(1) << sh_reg) : QB'(0));
        q_signed = neg_reg[idx_reg] ? -nrm_t'({1'b0, quo_next})
                                    : nrm_t'({1'b0, quo_next});
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        m_reg[0]   <= mag_in[0];
                        m_reg[1]   <= mag_in[1];
                        m_reg[2]   <= mag_in[2];
                        neg_reg[0] <= vin_x[VEC_W-1];
                        neg_reg[1] <= vin_y[VEC_W-1];
                        neg_reg[2] <= vin_z[VEC_W-1];
                        if ((mag_in[0] | mag_in[1] | mag_in[2]) == '0)
                        begin
                            q_reg[0] <= '0;
                            q_reg[1] <= '0;
                            q_reg[2] <= '0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= U_NORM;
                        end
                    end
                end
                // bring the largest magnitude into [2^29, 2^30)
                U_NORM:
                begin
                    if (|or_m[VEC_W-1:30])
                    begin
                        m_reg[0] <= m_reg[0] >> 1;
                        m_reg[1] <= m_reg[1] >> 1;
                        m_reg[2] <= m_reg[2] >> 1;
                    end
                    else if (!or_m[29])
                    begin
                        m_reg[0] <= m_reg[0] << 1;
                        m_reg[1] <= m_reg[1] << 1;
                        m_reg[2] <= m_reg[2] << 1;
                    end
                    else
                    begin
                        ss_reg    <= '0;
                        idx_reg   <= 2'd0;
                        state_reg <= U_SQ;
                    end
                end
                // sum of squares, one component a cycle
                U_SQ:
                begin
                    ss_reg <= sq_sum;
                    if (idx_reg == 2'd2)
                    begin
                        x_reg     <= sq_sum;
                        r_reg     <= '0;
                        bit_reg   <= SQ_W'(1) << 62;
                        state_reg <= U_SQRT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end
                // floor square root, two bits of radicand a cycle
                U_SQRT:
                begin
                    if (x_reg >= rb)
                    begin
                        x_reg <= x_reg - rb;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg == SQ_W'(1))
                    begin
                        idx_reg   <= 2'd0;
                        state_reg <= U_DIVLD;
                    end
                end
                // rounded dividend for one component
                U_DIVLD:
                begin
                    rem_reg   <= DIV_W'({m_lo, 14'd0}) + DIV_W'(nrm >> 1);
                    quo_reg   <= '0;
                    sh_reg    <= 4'(QB - 1);
                    state_reg <= U_DIV;
                end
                // restoring division, one quotient bit a cycle
                U_DIV:
                begin
                    if (ge)
                    begin
                        rem_reg <= rem_reg - den;
                    end
                    quo_reg <= quo_next;
                    sh_reg  <= sh_reg - 4'd1;
                    if (sh_reg == 4'd0)
                    begin
                        q_reg[idx_reg] <= q_signed;
                        if (idx_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= U_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 2'd1;
                            state_reg <= U_DIVLD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign q_x  = q_reg[0];
    assign q_y  = q_reg[1];
    assign q_z  = q_reg[2];

endmodule

// ===== rtl/vertex_normal_accumulator_unit.sv =====
// vertex normal accumulator top level: sequencer, position and sum memories
// depends on vna_pkg, vna_ram and vna_unit_vec
// a store or a rejected request finishes without the unit-vector unit; a face
//   or a read waits on its one-bit-a-cycle scaling, 32-step square root and
//   45-step division, which a degenerate face or a zero sum skips
// throughput: one item at a time; a result waiting in the output register
//   does not block the next request
// reset: asynchronous; afterwards a pass clears all 1024 entries of the sum memory and
//   no request is taken until it ends; vertex_count resets to zero
module vertex_normal_accumulator_unit
    import vna_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // opcode, vert_idx, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [143:0]     s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0]      m_tdata,
    // status
    output logic             m_tuser,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    localparam int EDGE_W = POS_W + 1;
    localparam int EL     = 23;
    localparam int PW     = 3 * POS_W;
    localparam int SW     = 3 * SUM_WIDTH;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_STORE, S_PA, S_PB, S_PC, S_PW, S_EDGE, S_SHIFT,
        S_CMUL, S_CSUB, S_RS, S_RD, S_UWAIT, S_SR, S_SW
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_reg;
    logic [CNT_W-1:0]    vcount_reg;
    logic [1:0]          op_reg;
    logic [ADDR_W-1:0]   vi_reg;
    logic [ADDR_W-1:0]   ca_reg, cb_reg, cc_reg;
    logic [PW-1:0]       pin_reg;
    logic [PW-1:0]       pa_reg, pb_reg;
    logic [EDGE_W-1:0]   em_reg [6];
    logic                en_reg [6];
    logic [1:0]          cidx_reg;
    logic signed [47:0]  p1_reg, p2_reg;
    vec_t                cr_reg [3];
    logic                bad_reg;
    logic                is_face_reg;
    logic                done_pend_reg;
    logic                m_tvalid_reg;
    logic [47:0]         m_tdata_reg;
    logic                m_tuser_reg;
    logic                uv_start_reg;

    logic [PW-1:0]       pos_rdata;
    logic [SW-1:0]       sum_rdata;
    logic                pos_we;
    logic [ADDR_W-1:0]   pos_raddr;
    logic                sum_we;
    logic [ADDR_W-1:0]   sum_waddr, sum_raddr;
    logic [SW-1:0]       sum_wdata;
    logic                uv_done;
    nrm_t                q_x, q_y, q_z;
    vec_t                uv_x, uv_y, uv_z;
    logic [ADDR_W-1:0]   k_addr;
    logic [EDGE_W-1:0]   e_or;
    logic signed [EDGE_W-1:0] ed [6];
    logic signed [EL:0]  es [6];
    logic signed [EL:0]  o1, o2, o3, o4;
    logic                in_fire;
    logic                out_free;
    logic [1:0]          in_op;
    logic [ADDR_W-1:0]   in_vi, in_ca, in_cb, in_cc;

    // saturating add of one normal component into an accumulator
    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] s,
                                                     input nrm_t d);
        logic signed [SUM_WIDTH:0] t;
        t = $signed({s[SUM_WIDTH-1], s}) + (SUM_WIDTH+1)'(d);
        if (t[SUM_WIDTH] != t[SUM_WIDTH-1])
        begin
            sat_add = t[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                   : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
        else
        begin
            sat_add = t[SUM_WIDTH-1:0];
        end
    endfunction

    // request fields
    assign in_op = s_tdata[1:0];
    assign in_vi = s_tdata[11:2];
    assign in_ca = s_tdata[117:108];
    assign in_cb = s_tdata[127:118];
    assign in_cc = s_tdata[137:128];

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // corner selected by the accumulate loop
    always_comb
    begin
        case (cidx_reg)
            2'd0:    k_addr = ca_reg;
            2'd1:    k_addr = cb_reg;
            default: k_addr = cc_reg;
        endcase
    end

    // edge differences from the three fetched corners
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ed[i]   = $signed({pb_reg[i*POS_W+POS_W-1], pb_reg[i*POS_W +: POS_W]})
                    - $signed({pa_reg[i*POS_W+POS_W-1], pa_reg[i*POS_W +: POS_W]});
            ed[i+3] = $signed({pos_rdata[i*POS_W+POS_W-1], pos_rdata[i*POS_W +: POS_W]})
                    - $signed({pa_reg[i*POS_W+POS_W-1], pa_reg[i*POS_W +: POS_W]});
        end
        e_or = '0;
        for (int i = 0; i < 6; i++)
        begin
            e_or  = e_or | em_reg[i];
            es[i] = en_reg[i] ? -$signed({1'b0, em_reg[i][EL-1:0]})
                              : $signed({1'b0, em_reg[i][EL-1:0]});
        end
    end

    // operand pairs of the cross product
    always_comb
    begin
        case (cidx_reg)
            2'd0:
            begin
                o1 = es[1]; o2 = es[5]; o3 = es[2]; o4 = es[4];
            end
            2'd1:
            begin
                o1 = es[2]; o2 = es[3]; o3 = es[0]; o4 = es[5];
            end
            default:
            begin
                o1 = es[0]; o2 = es[4]; o3 = es[1]; o4 = es[3];
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        pos_we    = (state_reg == S_STORE);
        pos_raddr = ca_reg;
        case (state_reg)
            S_PB:       pos_raddr = cb_reg;
            S_PC, S_PW: pos_raddr = cc_reg;
            default:    pos_raddr = ca_reg;
        endcase
        sum_we    = 1'b0;
        sum_waddr = vi_reg;
        sum_wdata = '0;
        sum_raddr = (state_reg inside {S_RS, S_RD}) ? vi_reg : k_addr;
        case (state_reg)
            S_CLEAR:
            begin
                sum_we    = 1'b1;
                sum_waddr = clr_reg;
            end
            S_STORE:
            begin
                sum_we = 1'b1;
            end
            S_SW:
            begin
                sum_we    = 1'b1;
                sum_waddr = k_addr;
                sum_wdata = {sat_add(sum_rdata[2*SUM_WIDTH +: SUM_WIDTH], q_z),
                             sat_add(sum_rdata[SUM_WIDTH +: SUM_WIDTH], q_y),
                             sat_add(sum_rdata[0 +: SUM_WIDTH], q_x)};
            end
            default:
            begin
                sum_we = 1'b0;
            end
        endcase
    end

    // vector fed to the unit-vector unit
    always_comb
    begin
        if (is_face_reg)
        begin
            uv_x = cr_reg[0];
            uv_y = cr_reg[1];
            uv_z = cr_reg[2];
        end
        else
        begin
            uv_x = vec_t'($signed(sum_rdata[0 +: SUM_WIDTH]));
            uv_y = vec_t'($signed(sum_rdata[SUM_WIDTH +: SUM_WIDTH]));
            uv_z = vec_t'($signed(sum_rdata[2*SUM_WIDTH +: SUM_WIDTH]));
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            vcount_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            uv_start_reg  <= 1'b0;
            done_pend_reg <= 1'b0;
        end
        else
        begin
            uv_start_reg <= 1'b0;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            // finished item waits here for the output register
            if (done_pend_reg && out_free)
            begin
                m_tvalid_reg  <= 1'b1;
                m_tuser_reg   <= bad_reg;
                m_tdata_reg   <= (op_reg == OP_READ && !bad_reg)
                                 ? {q_z, q_y, q_x} : '0;
                done_pend_reg <= 1'b0;
                state_reg     <= S_IDLE;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(MAX_VERTICES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg      <= in_op;
                        vi_reg      <= in_vi;
                        ca_reg      <= in_ca;
                        cb_reg      <= in_cb;
                        cc_reg      <= in_cc;
                        pin_reg     <= s_tdata[107:12];
                        cidx_reg    <= 2'd0;
                        is_face_reg <= (in_op == OP_FACE);
                        bad_reg     <= 1'b0;
                        case (in_op)
                            OP_STORE:
                            begin
                                if (CNT_W'(in_vi) < vcount_reg)
                                begin
                                    state_reg <= S_STORE;
                                end
                                else
                                begin
                                    bad_reg       <= 1'b1;
                                    done_pend_reg <= 1'b1;
                                    state_reg     <= S_UWAIT;
                                end
                            end
                            OP_FACE:
                            begin
                                if (CNT_W'(in_ca) < vcount_reg
                                    && CNT_W'(in_cb) < vcount_reg
                                    && CNT_W'(in_cc) < vcount_reg)
                                begin
                                    state_reg <= S_PA;
                                end
                                else
                                begin
                                    bad_reg       <= 1'b1;
                                    done_pend_reg <= 1'b1;
                                    state_reg     <= S_UWAIT;
                                end
                            end
                            OP_READ:
                            begin
                                if (CNT_W'(in_vi) < vcount_reg)
                                begin
                                    state_reg <= S_RS;
                                end
                                else
                                begin
                                    bad_reg       <= 1'b1;
                                    done_pend_reg <= 1'b1;
                                    state_reg     <= S_UWAIT;
                                end
                            end
                            default:
                            begin
                                bad_reg       <= 1'b1;
                                done_pend_reg <= 1'b1;
                                state_reg     <= S_UWAIT;
                            end
                        endcase
                    end
                end
                S_STORE:
                begin
                    done_pend_reg <= 1'b1;
                    state_reg     <= S_UWAIT;
                end
                // fetch the three corner positions
                S_PA:
                begin
                    state_reg <= S_PB;
                end
                S_PB:
                begin
                    pa_reg    <= pos_rdata;
                    state_reg <= S_PC;
                end
                S_PC:
                begin
                    pb_reg    <= pos_rdata;
                    state_reg <= S_PW;
                end
                S_PW:
                begin
                    state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        en_reg[i] <= ed[i][EDGE_W-1];
                        em_reg[i] <= ed[i][EDGE_W-1] ? EDGE_W'(-ed[i]) : EDGE_W'(ed[i]);
                    end
                    state_reg <= S_SHIFT;
                end
                // scale edges until the largest magnitude is below 2^23
                S_SHIFT:
                begin
                    if (|e_or[EDGE_W-1:EL])
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            em_reg[i] <= em_reg[i] >> 1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CMUL;
                    end
                end
                // cross product, one component per pass through S_CMUL and S_CSUB
                S_CMUL:
                begin
                    p1_reg    <= o1 * o2;
                    p2_reg    <= o3 * o4;
                    state_reg <= S_CSUB;
                end
                S_CSUB:
                begin
                    cr_reg[cidx_reg] <= p1_reg - p2_reg;
                    if (cidx_reg == 2'd2)
                    begin
                        cidx_reg     <= 2'd0;
                        uv_start_reg <= 1'b1;
                        state_reg    <= S_UWAIT;
                    end
                    else
                    begin
                        cidx_reg  <= cidx_reg + 2'd1;
                        state_reg <= S_CMUL;
                    end
                end
                // read path: fetch the accumulator
                S_RS:
                begin
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    uv_start_reg <= 1'b1;
                    state_reg    <= S_UWAIT;
                end
                S_UWAIT:
                begin
                    if (uv_done)
                    begin
                        if (is_face_reg)
                        begin
                            state_reg <= S_SR;
                        end
                        else
                        begin
                            done_pend_reg <= 1'b1;
                        end
                    end
                end
                // accumulate into each corner, read then write back
                S_SR:
                begin
                    state_reg <= S_SW;
                end
                S_SW:
                begin
                    if (cidx_reg == 2'd2)
                    begin
                        done_pend_reg <= 1'b1;
                        state_reg     <= S_UWAIT;
                    end
                    else
                    begin
                        cidx_reg  <= cidx_reg + 2'd1;
                        state_reg <= S_SR;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    vna_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (vi_reg),
        .wdata (pin_reg),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    vna_unit_vec u_unit_vec (
        .clk   (clk),
        .rst_n (rst_n),
        .start (uv_start_reg),
        .vin_x (uv_x),
        .vin_y (uv_y),
        .vin_z (uv_z),
        .done  (uv_done),
        .q_x   (q_x),
        .q_y   (q_y),
        .q_z   (q_z)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // no request is taken while the sum memory is being cleared
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("request accepted during clear pass");

    // an error result carries zero normals
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with nonzero normal");

    // the unit-vector unit only finishes while the sequencer waits for it
    a_uv_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        uv_done |-> state_reg == S_UWAIT)
        else $error("unit-vector result arrived outside wait state");

    // a started unit-vector job is never overlapped by a new request
    a_uv_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        uv_start_reg |-> !s_tready)
        else $error("request window open during normalization");
`endif

endmodule

// ===== sim/vertex_normal_accumulator_unit_tb.sv =====
// self-checking testbench for the vertex normal accumulator unit
// depends on vna_pkg and the rtl of vertex_normal_accumulator_unit
module vertex_normal_accumulator_unit_tb;
    import vna_pkg::*;

    localparam logic [1:0] OP_BAD   = 2'd3;
    localparam int         WD_LIMIT = 20000;
    localparam int         SETTLE   = 200;
    localparam longint     SUM_HI   = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
    localparam longint     SUM_LO   = -SUM_HI - 1;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] vidx;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  pz;
        logic [ADDR_W-1:0] ca;
        logic [ADDR_W-1:0] cb;
        logic [ADDR_W-1:0] cc;
    } req_t;

    typedef struct packed {
        logic status;
        nrm_t nx;
        nrm_t ny;
        nrm_t nz;
    } normal_rsp_t;

    typedef struct {
        int          new_count;
        req_t        req;
        bit          typed;
        normal_rsp_t rsp;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [143:0]     s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [47:0]      m_tdata;
    logic             m_tuser;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    // predictor copy of the block state
    logic signed [POS_W-1:0] pos_x_mem [MAX_VERTICES];
    logic signed [POS_W-1:0] pos_y_mem [MAX_VERTICES];
    logic signed [POS_W-1:0] pos_z_mem [MAX_VERTICES];
    longint                  sum_x_mem [MAX_VERTICES];
    longint                  sum_y_mem [MAX_VERTICES];
    longint                  sum_z_mem [MAX_VERTICES];
    bit                      stored    [MAX_VERTICES];
    int                      vert_count;

    normal_rsp_t normal_q[$];
    row_t        rows[$];
    int          errors;
    int          idle_cycles;
    int          snd_idle;
    int          rcv_idle;

    vertex_normal_accumulator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor square root, two bits a step
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector in q1.14, zero for a zero input
    task automatic unit_vector(input longint cx, input longint cy, input longint cz,
                               output longint qx, output longint qy, output longint qz);
        longint unsigned mx, my, mz, big, ss, nrm;
        mx = (cx < 0) ? -cx : cx;
        my = (cy < 0) ? -cy : cy;
        mz = (cz < 0) ? -cz : cz;
        big = mx;
        if (my > big) big = my;
        if (mz > big) big = mz;
        qx = 0;
        qy = 0;
        qz = 0;
        if (big != 0)
        begin
            while (big >= (64'd1 << 30))
            begin
                mx = mx >> 1; my = my >> 1; mz = mz >> 1; big = big >> 1;
            end
            while (big < (64'd1 << 29))
            begin
                mx = mx << 1; my = my << 1; mz = mz << 1; big = big << 1;
            end
            ss  = mx * mx + my * my + mz * mz;
            nrm = floor_sqrt(ss);
            qx  = longint'((mx * 16384 + nrm / 2) / nrm);
            qy  = longint'((my * 16384 + nrm / 2) / nrm);
            qz  = longint'((mz * 16384 + nrm / 2) / nrm);
            if (cx < 0) qx = -qx;
            if (cy < 0) qy = -qy;
            if (cz < 0) qz = -qz;
        end
    endtask

    function automatic longint sat_sum(input longint s, input longint d);
        longint r;
        r = s + d;
        if (r > SUM_HI) r = SUM_HI;
        if (r < SUM_LO) r = SUM_LO;
        return r;
    endfunction

    function automatic bit index_ok(input int i);
        return i < vert_count && i < MAX_VERTICES;
    endfunction

    // face normal from edge cross product, added to all three corners
    task automatic accumulate_face(input int a, input int b, input int c);
        longint          e[6];
        longint unsigned m[6];
        longint unsigned big;
        longint          crx, cry, crz, nx, ny, nz;
        int              k[3];
        e[0] = longint'(pos_x_mem[b]) - longint'(pos_x_mem[a]);
        e[1] = longint'(pos_y_mem[b]) - longint'(pos_y_mem[a]);
        e[2] = longint'(pos_z_mem[b]) - longint'(pos_z_mem[a]);
        e[3] = longint'(pos_x_mem[c]) - longint'(pos_x_mem[a]);
        e[4] = longint'(pos_y_mem[c]) - longint'(pos_y_mem[a]);
        e[5] = longint'(pos_z_mem[c]) - longint'(pos_z_mem[a]);
        big = 0;
        for (int i = 0; i < 6; i++)
        begin
            m[i] = (e[i] < 0) ? -e[i] : e[i];
            if (m[i] > big) big = m[i];
        end
        // edges scaled together so the cross product fits in 48 bits
        while (big >= (64'd1 << 23))
        begin
            for (int i = 0; i < 6; i++) m[i] = m[i] >> 1;
            big = big >> 1;
        end
        for (int i = 0; i < 6; i++) e[i] = (e[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
        crx = e[1] * e[5] - e[2] * e[4];
        cry = e[2] * e[3] - e[0] * e[5];
        crz = e[0] * e[4] - e[1] * e[3];
        unit_vector(crx, cry, crz, nx, ny, nz);
        k[0] = a; k[1] = b; k[2] = c;
        for (int i = 0; i < 3; i++)
        begin
            sum_x_mem[k[i]] = sat_sum(sum_x_mem[k[i]], nx);
            sum_y_mem[k[i]] = sat_sum(sum_y_mem[k[i]], ny);
            sum_z_mem[k[i]] = sat_sum(sum_z_mem[k[i]], nz);
        end
    endtask

    // expected response of one request, state updated on the way
    task automatic predict_normal(input req_t r, output normal_rsp_t rsp);
        longint qx, qy, qz;
        qx = 0; qy = 0; qz = 0;
        rsp.status = 1'b0;
        case (r.op)
            OP_STORE:
                if (index_ok(r.vidx))
                begin
                    pos_x_mem[r.vidx] = r.px;
                    pos_y_mem[r.vidx] = r.py;
                    pos_z_mem[r.vidx] = r.pz;
                    sum_x_mem[r.vidx] = 0;
                    sum_y_mem[r.vidx] = 0;
                    sum_z_mem[r.vidx] = 0;
                    stored[r.vidx]    = 1'b1;
                end
                else
                    rsp.status = 1'b1;
            OP_FACE:
                if (index_ok(r.ca) && index_ok(r.cb) && index_ok(r.cc))
                    accumulate_face(r.ca, r.cb, r.cc);
                else
                    rsp.status = 1'b1;
            OP_READ:
                if (index_ok(r.vidx))
                    unit_vector(sum_x_mem[r.vidx], sum_y_mem[r.vidx], sum_z_mem[r.vidx],
                                qx, qy, qz);
                else
                    rsp.status = 1'b1;
            default:
                rsp.status = 1'b1;
        endcase
        rsp.nx = nrm_t'(qx);
        rsp.ny = nrm_t'(qy);
        rsp.nz = nrm_t'(qz);
    endtask

    // drive one request, with a random gap before it
    task automatic send_request(input req_t r, input bit typed, input normal_rsp_t typed_rsp);
        normal_rsp_t rsp;
        predict_normal(r, rsp);
        normal_q.insert(normal_q.size(), typed ? typed_rsp : rsp);
        if ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r.cc, r.cb, r.ca, r.pz, r.py, r.px, r.vidx, r.op};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending and wait for every response plus the block's tail
    task automatic drain;
        s_tvalid <= 1'b0;
        while (normal_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input int value);
        drain();
        cfg_we     <= 1'b1;
        cfg_wdata  <= CNT_W'(value);
        @(posedge clk);
        cfg_we     <= 1'b0;
        vert_count = value;
    endtask

    function automatic req_t make_req(input logic [1:0] op, input int vidx,
                                      input logic [31:0] px, input logic [31:0] py,
                                      input logic [31:0] pz,
                                      input int ca, input int cb, input int cc);
        req_t r;
        r.op = op; r.vidx = ADDR_W'(vidx);
        r.px = px; r.py = py; r.pz = pz;
        r.ca = ADDR_W'(ca); r.cb = ADDR_W'(cb); r.cc = ADDR_W'(cc);
        return r;
    endfunction

    task automatic add_row(input int new_count, input req_t r, input bit typed,
                           input logic st, input int nx, input int ny, input int nz);
        row_t w;
        w.new_count = new_count;
        w.req       = r;
        w.typed     = typed;
        w.rsp       = '{st, nrm_t'(nx), nrm_t'(ny), nrm_t'(nz)};
        rows.insert(rows.size(), w);
    endtask

    // a stored vertex below the current count, vertex zero as fallback
    function automatic int pick_stored();
        int lim, v;
        lim = (vert_count < MAX_VERTICES) ? vert_count : MAX_VERTICES;
        for (int t = 0; t < 64; t++)
        begin
            v = $urandom_range(lim - 1);
            if (stored[v]) return v;
        end
        return 0;
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(1))
            return $urandom;
        return 32'($signed($urandom_range(2 * 1048576)) - 1048576);
    endfunction

    function automatic int rand_index();
        if ($urandom_range(99) < 90)
            return $urandom_range(((vert_count < MAX_VERTICES) ? vert_count : MAX_VERTICES) - 1);
        return $urandom_range(MAX_VERTICES - 1);
    endfunction

    task automatic send_random();
        int          sel, a, b, c;
        req_t        r;
        normal_rsp_t none;
        none = '0;
        sel  = $urandom_range(99);
        if (sel < 25)
            r = make_req(OP_STORE, rand_index(), rand_coord(), rand_coord(), rand_coord(),
                         $urandom, $urandom, $urandom);
        else if (sel < 65)
        begin
            a = pick_stored(); b = pick_stored(); c = pick_stored();
            // some faces with corners anywhere; any bad one rejects the face
            if ($urandom_range(99) < 15)
            begin
                a = $urandom_range(MAX_VERTICES - 1);
                b = $urandom_range(MAX_VERTICES - 1);
                c = $urandom_range(MAX_VERTICES - 1);
                if (index_ok(a) && index_ok(b) && index_ok(c)
                    && !(stored[a] && stored[b] && stored[c]))
                begin
                    a = pick_stored(); b = pick_stored(); c = pick_stored();
                end
            end
            r = make_req(OP_FACE, $urandom, $urandom, $urandom, $urandom, a, b, c);
        end
        else if (sel < 95)
            r = make_req(OP_READ, rand_index(), $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        else
            r = make_req(OP_BAD, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
        send_request(r, 1'b0, none);
    endtask

    // response checker and receiver stalls
    always @(posedge clk)
    begin
        normal_rsp_t want;
        normal_rsp_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]};
            if (normal_q.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d n=(%0d,%0d,%0d)", $time,
                         got.status, got.nx, got.ny, got.nz);
                errors++;
            end
            else
            begin
                want = normal_q.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    errors++;
                end
                if (got.nx !== want.nx)
                begin
                    $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, got.nx);
                    errors++;
                end
                if (got.ny !== want.ny)
                begin
                    $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, got.ny);
                    errors++;
                end
                if (got.nz !== want.nz)
                begin
                    $display("%0t: normal_z expected %0d actual %0d", $time, want.nz, got.nz);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        normal_rsp_t none;
        int          phase_count[3];
        none        = '0;
        errors      = 0;
        idle_cycles = 0;
        snd_idle    = 0;
        rcv_idle    = 0;
        vert_count  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            pos_x_mem[i] = 0; pos_y_mem[i] = 0; pos_z_mem[i] = 0;
            sum_x_mem[i] = 0; sum_y_mem[i] = 0; sum_z_mem[i] = 0;
            stored[i]    = 1'b0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; count zero after reset rejects everything
        add_row(-1,   make_req(OP_READ,  5, 0, 0, 0, 0, 0, 0), 1, 1'b1, 0, 0, 0);
        add_row(-1,   make_req(OP_STORE, 0, 0, 0, 0, 0, 0, 0), 1, 1'b1, 0, 0, 0);
        add_row(-1,   make_req(OP_FACE,  0, 0, 0, 0, 0, 1, 2), 1, 1'b1, 0, 0, 0);
        add_row(1024, make_req(OP_STORE, 0, 0, 0, 0, 0, 0, 0), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_STORE, 1, 32'h10000, 0, 0, 0, 0, 0), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_STORE, 2, 0, 32'h10000, 0, 0, 0, 0), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_FACE,  0, 0, 0, 0, 0, 1, 2), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_READ,  0, 0, 0, 0, 0, 0, 0), 1, 1'b0, 0, 0, 16384);
        add_row(-1,   make_req(OP_READ,  1, 0, 0, 0, 0, 0, 0), 0, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_STORE, 3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               0, 0, 0), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_STORE, 4, 32'h80000000, 32'h80000000, 32'h80000000,
                               0, 0, 0), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_STORE, 5, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0),
                1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_FACE,  0, 0, 0, 0, 3, 4, 5), 0, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_READ,  3, 0, 0, 0, 0, 0, 0), 0, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_READ,  5, 0, 0, 0, 0, 0, 0), 0, 1'b0, 0, 0, 0);
        // degenerate face adds nothing
        add_row(-1,   make_req(OP_FACE,  0, 0, 0, 0, 0, 0, 1), 1, 1'b0, 0, 0, 0);
        // zero sum reads as zero
        add_row(-1,   make_req(OP_READ,  9, 0, 0, 0, 0, 0, 0), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_STORE, 1023, 32'hffff0000, 5, 7, 0, 0, 0), 1, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_FACE,  0, 0, 0, 0, 1023, 0, 2), 0, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_READ,  1023, 0, 0, 0, 0, 0, 0), 0, 1'b0, 0, 0, 0);
        add_row(-1,   make_req(OP_BAD,   1, 0, 0, 0, 1, 2, 3), 1, 1'b1, 0, 0, 0);
        add_row(-1,   make_req(OP_READ,  2, 0, 0, 0, 0, 0, 0), 0, 1'b0, 0, 0, 0);
        foreach (rows[i])
        begin
            if (rows[i].new_count >= 0)
                write_count(rows[i].new_count);
            send_request(rows[i].req, rows[i].typed, rows[i].rsp);
        end

        // random phases, each with its own count and idling mix
        phase_count[0] = 1023;
        phase_count[1] = 1024;
        phase_count[2] = 5;
        for (int ph = 0; ph < 3; ph++)
        begin
            write_count(phase_count[ph]);
            snd_idle = (ph == 0) ? 34 : (ph == 1) ? 85 : 0;
            rcv_idle = (ph == 0) ? 85 : (ph == 1) ? 34 : 0;
            for (int n = 0; n < 260; n++) send_random();
            // same face over and over drives the sums into saturation
            if (ph == 1)
            begin
                send_request(make_req(OP_STORE, 10, 0, 0, 0, 0, 0, 0), 1'b0, none);
                send_request(make_req(OP_STORE, 11, 32'h10000, 0, 0, 0, 0, 0), 1'b0, none);
                send_request(make_req(OP_STORE, 12, 0, 32'h10000, 0, 0, 0, 0), 1'b0, none);
                for (int n = 0; n < 520; n++)
                    send_request(make_req(OP_FACE, 0, 0, 0, 0, 10, 11, 12), 1'b0, none);
                send_request(make_req(OP_READ, 10, 0, 0, 0, 0, 0, 0), 1'b0, none);
            end
        end

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
